/* sv/ipaf_pkg.sv */
package ipaf_pkg;

   localparam int RULE_ENTRIES_DEF  = 64;
   localparam int RANGE_ENTRIES_DEF = 64;

   typedef enum logic [1:0] {
      OP_ADD_RULE  = 2'd0,
      OP_ADD_RANGE = 2'd1,
      OP_CLEAR     = 2'd2,
      OP_CHECK     = 2'd3
   } op_type;

   typedef struct packed {
      logic [31:0] octets;
      logic [3:0]  wildcards;
      logic        allow;
   } rule_entry_type;

   typedef struct packed {
      logic [31:0] first;
      logic [31:0] last;
   } range_entry_type;

   function automatic logic [31:0] care_mask(input logic [3:0] wild);
      logic [31:0] m;
      m = {{8{~wild[3]}}, {8{~wild[2]}}, {8{~wild[1]}}, {8{~wild[0]}}};
      return m;
   endfunction

   function automatic logic rule_hit(input rule_entry_type r, input logic [31:0] addr);
      return ((addr ^ r.octets) & care_mask(r.wildcards)) == 32'd0;
   endfunction

endpackage

/* sv/ip_access_filter.sv */
// Add rule, add range and clear answer in the cycle after start; busy stays low.
// Check: answered in the cycle after start with both tables empty, else after the scan and drain states;
// both tables are scanned in parallel, one entry of each per cycle through their memories.
// Throughput: one add or clear per cycle; a check of non-empty tables holds busy until its answer.
// Reset clears both counts and the state machine; table memories are not cleared.
// Each answer is shown for one cycle with rsp_valid; the receiver cannot stall.
module ip_access_filter #(
   parameter int RULE_ENTRIES  = ipaf_pkg::RULE_ENTRIES_DEF,
   parameter int RANGE_ENTRIES = ipaf_pkg::RANGE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_address,
   input  logic [31:0] req_range_end,
   input  logic [3:0]  req_wildcard_mask,
   input  logic        req_rule_allow,
   output logic        rsp_valid,
   output logic        rsp_allowed,
   output logic        rsp_blocked,
   output logic        rsp_status
);
   import ipaf_pkg::*;

   localparam int RULE_IW  = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
   localparam int RANGE_IW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
   localparam int RULE_CW  = $clog2(RULE_ENTRIES + 1);
   localparam int RANGE_CW = $clog2(RANGE_ENTRIES + 1);
   localparam int MAX_ENTRIES = (RULE_ENTRIES > RANGE_ENTRIES) ? RULE_ENTRIES : RANGE_ENTRIES;
   localparam int SCAN_W   = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   rule_entry_type  rule_mem  [RULE_ENTRIES];
   range_entry_type range_mem [RANGE_ENTRIES];

   state_type          state_ff, state_in;
   logic [RULE_CW-1:0] rule_count_ff;
   logic [RANGE_CW-1:0] range_count_ff;
   logic [SCAN_W-1:0]  scan_ff;
   logic [31:0]        addr_ff;
   rule_entry_type     rule_rd_ff;
   range_entry_type    range_rd_ff;
   logic               rule_rd_v_ff, range_rd_v_ff, rd_last_ff;
   logic               any_allow_ff, any_deny_ff, blocked_ff;
   logic               rsp_valid_ff, rsp_allowed_ff, rsp_blocked_ff, rsp_status_ff;

   logic               accept;
   op_type             op;
   logic               rule_full, range_full;
   logic [SCAN_W-1:0]  rule_cnt_x, range_cnt_x, scan_max;
   logic               scan_rule_v, scan_range_v, scan_last;
   logic               hit_allow, hit_deny, hit_range;

   assign accept     = start && !busy;
   assign op         = op_type'(req_operation);
   assign rule_full  = rule_count_ff == RULE_CW'(RULE_ENTRIES);
   assign range_full = range_count_ff == RANGE_CW'(RANGE_ENTRIES);
   assign rule_cnt_x  = SCAN_W'(rule_count_ff);
   assign range_cnt_x = SCAN_W'(range_count_ff);
   assign scan_max     = (rule_cnt_x > range_cnt_x) ? rule_cnt_x : range_cnt_x;
   assign scan_rule_v  = scan_ff < rule_cnt_x;
   assign scan_range_v = scan_ff < range_cnt_x;
   assign scan_last    = (scan_ff + SCAN_W'(1)) == scan_max;

   assign hit_allow = rule_rd_v_ff && rule_hit(rule_rd_ff, addr_ff) && rule_rd_ff.allow;
   assign hit_deny  = rule_rd_v_ff && rule_hit(rule_rd_ff, addr_ff) && !rule_rd_ff.allow;
   assign hit_range = range_rd_v_ff && (addr_ff >= range_rd_ff.first)
                      && (addr_ff <= range_rd_ff.last);

   always_ff @(posedge clock) begin
      if (accept && op == OP_ADD_RULE && !rule_full) begin
         rule_mem[rule_count_ff[RULE_IW-1:0]] <= '{octets: req_address,
                                                   wildcards: req_wildcard_mask,
                                                   allow: req_rule_allow};
      end
      if (state_ff == ST_SCAN && scan_rule_v) begin
         rule_rd_ff <= rule_mem[scan_ff[RULE_IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && op == OP_ADD_RANGE && !range_full) begin
         range_mem[range_count_ff[RANGE_IW-1:0]] <= '{first: req_address, last: req_range_end};
      end
      if (state_ff == ST_SCAN && scan_range_v) begin
         range_rd_ff <= range_mem[scan_ff[RANGE_IW-1:0]];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && op == OP_CHECK && scan_max != '0) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rd_last_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rule_count_ff  <= '0;
         range_count_ff <= '0;
         rule_rd_v_ff   <= 1'b0;
         range_rd_v_ff  <= 1'b0;
         rd_last_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= 1'b0;
         rule_rd_v_ff  <= (state_ff == ST_SCAN) && scan_rule_v;
         range_rd_v_ff <= (state_ff == ST_SCAN) && scan_range_v;
         rd_last_ff    <= (state_ff == ST_SCAN) && scan_last;

         if (accept) begin
            addr_ff        <= req_address;
            scan_ff        <= '0;
            any_allow_ff   <= 1'b0;
            any_deny_ff    <= 1'b0;
            blocked_ff     <= 1'b0;
            rsp_allowed_ff <= 1'b0;
            rsp_blocked_ff <= 1'b0;
            rsp_status_ff  <= 1'b0;
            case (op)
               OP_ADD_RULE: begin
                  rsp_valid_ff <= 1'b1;
                  if (rule_full) rsp_status_ff <= 1'b1;
                  else rule_count_ff <= rule_count_ff + RULE_CW'(1);
               end
               OP_ADD_RANGE: begin
                  rsp_valid_ff <= 1'b1;
                  if (range_full) rsp_status_ff <= 1'b1;
                  else range_count_ff <= range_count_ff + RANGE_CW'(1);
               end
               OP_CLEAR: begin
                  rsp_valid_ff   <= 1'b1;
                  rule_count_ff  <= '0;
                  range_count_ff <= '0;
               end
               OP_CHECK: begin
                  if (scan_max == '0) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_allowed_ff <= 1'b1;
                  end
               end
               default: rsp_valid_ff <= 1'b0;
            endcase
         end else begin
            if (state_ff == ST_SCAN) scan_ff <= scan_ff + SCAN_W'(1);
            any_allow_ff <= any_allow_ff || hit_allow;
            any_deny_ff  <= any_deny_ff || hit_deny;
            blocked_ff   <= blocked_ff || hit_range;
            if (rd_last_ff) begin
               rsp_valid_ff   <= 1'b1;
               rsp_allowed_ff <= any_allow_ff || hit_allow || !(any_deny_ff || hit_deny);
               rsp_blocked_ff <= blocked_ff || hit_range;
               rsp_status_ff  <= 1'b0;
            end
         end
      end
   end

   assign busy        = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;
   assign rsp_blocked = rsp_blocked_ff;
   assign rsp_status  = rsp_status_ff;

   a_add_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_operation != OP_CHECK |=> rsp_valid)
      else $error("add or clear beat without answer");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(busy) |-> !busy)
      else $error("check answered while scan still running");

   a_full_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_allowed && !rsp_blocked)
      else $error("dropped insert carries check flags");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rule_count_ff <= RULE_CW'(RULE_ENTRIES) && range_count_ff <= RANGE_CW'(RANGE_ENTRIES))
      else $error("table count beyond depth");

endmodule

/* tb/ipaf_checker.sv */
module ipaf_checker #(
   parameter int RULE_ENTRIES  = ipaf_pkg::RULE_ENTRIES_DEF,
   parameter int RANGE_ENTRIES = ipaf_pkg::RANGE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_address,
   input  logic [31:0] req_range_end,
   input  logic [3:0]  req_wildcard_mask,
   input  logic        req_rule_allow,
   input  logic        rsp_valid,
   input  logic        rsp_allowed,
   input  logic        rsp_blocked,
   input  logic        rsp_status,
   output int          fail_count,
   output int          answers_pending
);
   import ipaf_pkg::*;

   typedef struct packed {
      logic allowed;
      logic blocked;
      logic status;
   } answer_type;

   rule_entry_type  rules  [RULE_ENTRIES];
   range_entry_type ranges [RANGE_ENTRIES];
   int              rules_held;
   int              ranges_held;
   int              mismatches;
   answer_type      answers_due [$];
   answer_type      due_answer;
   answer_type      next_answer;

   function automatic answer_type screen_request(input op_type op, input logic [31:0] addr,
                                                 input logic [31:0] rend, input logic [3:0] wild,
                                                 input logic allow_in);
      answer_type ans;
      logic       any_allow;
      logic       any_deny;
      logic       hit;
      int         i;
      int         k;
      ans = '0;
      case (op)
         OP_ADD_RULE: begin
            if (rules_held < RULE_ENTRIES) begin
               rules[rules_held].octets    = addr;
               rules[rules_held].wildcards = wild;
               rules[rules_held].allow     = allow_in;
               rules_held++;
            end else begin
               ans.status = 1'b1;
            end
         end
         OP_ADD_RANGE: begin
            if (ranges_held < RANGE_ENTRIES) begin
               ranges[ranges_held].first = addr;
               ranges[ranges_held].last  = rend;
               ranges_held++;
            end else begin
               ans.status = 1'b1;
            end
         end
         OP_CLEAR: begin
            rules_held  = 0;
            ranges_held = 0;
         end
         default: begin
            any_allow = 1'b0;
            any_deny  = 1'b0;
            for (i = 0; i < rules_held; i++) begin
               hit = 1'b1;
               for (k = 0; k < 4; k++) begin
                  if (!rules[i].wildcards[k] && addr[8*k +: 8] != rules[i].octets[8*k +: 8])
                     hit = 1'b0;
               end
               if (hit && rules[i].allow)
                  any_allow = 1'b1;
               else if (hit)
                  any_deny = 1'b1;
            end
            ans.allowed = any_allow || !any_deny;
            for (i = 0; i < ranges_held; i++) begin
               if (addr >= ranges[i].first && addr <= ranges[i].last)
                  ans.blocked = 1'b1;
            end
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rules_held  = 0;
         ranges_held = 0;
         answers_due.delete();
      end else begin
         if (rsp_valid !== 1'b0) begin
            if (answers_due.size() == 0) begin
               $error("unexpected answer beat: allowed %0b blocked %0b status %0b",
                      rsp_allowed, rsp_blocked, rsp_status);
               mismatches++;
            end else begin
               due_answer = answers_due.pop_front();
               if (rsp_allowed !== due_answer.allowed) begin
                  $error("allowed: expected %0b, got %0b", due_answer.allowed, rsp_allowed);
                  mismatches++;
               end
               if (rsp_blocked !== due_answer.blocked) begin
                  $error("blocked: expected %0b, got %0b", due_answer.blocked, rsp_blocked);
                  mismatches++;
               end
               if (rsp_status !== due_answer.status) begin
                  $error("status: expected %0b, got %0b", due_answer.status, rsp_status);
                  mismatches++;
               end
            end
         end
         if (start && busy === 1'b0) begin
            next_answer = screen_request(op_type'(req_operation), req_address,
                                         req_range_end, req_wildcard_mask,
                                         req_rule_allow);
            answers_due = {answers_due, next_answer};
         end
      end
      answers_pending <= answers_due.size();
      fail_count      <= mismatches;
   end

endmodule

/* tb/testbench.sv */
module testbench;
   import ipaf_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int ITEM_TARGET = 1700;
   localparam int DRAIN_WAIT  = 80;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        start             = 1'b0;
   logic [1:0]  req_operation     = OP_CHECK;
   logic [31:0] req_address       = '0;
   logic [31:0] req_range_end     = '0;
   logic [3:0]  req_wildcard_mask = '0;
   logic        req_rule_allow    = 1'b0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_allowed;
   logic        rsp_blocked;
   logic        rsp_status;
   int          fail_count;
   int          answers_pending;

   int          stall_cycles = 0;
   int          items_sent   = 0;
   int          burst_left   = 0;
   logic [31:0] addr_pool [$];

   logic        crowded;
   int          phase_len;
   int          add_weight;
   int          pick;
   int          kind;
   logic [31:0] lo;
   logic [31:0] hi;
   logic [32:0] span;

   always #2 clock = ~clock;

   ip_access_filter u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_address       (req_address),
      .req_range_end     (req_range_end),
      .req_wildcard_mask (req_wildcard_mask),
      .req_rule_allow    (req_rule_allow),
      .rsp_valid         (rsp_valid),
      .rsp_allowed       (rsp_allowed),
      .rsp_blocked       (rsp_blocked),
      .rsp_status        (rsp_status)
   );

   ipaf_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_address       (req_address),
      .req_range_end     (req_range_end),
      .req_wildcard_mask (req_wildcard_mask),
      .req_rule_allow    (req_rule_allow),
      .rsp_valid         (rsp_valid),
      .rsp_allowed       (rsp_allowed),
      .rsp_blocked       (rsp_blocked),
      .rsp_status        (rsp_status),
      .fail_count        (fail_count),
      .answers_pending   (answers_pending)
   );

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [31:0] pool_pick();
      if (addr_pool.size() == 0)
         return $urandom;
      return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
   endfunction

   // Drive one beat; fields the operation ignores get random values.
   task automatic issue(input op_type op, input logic [31:0] addr, input logic [31:0] rend,
                        input logic [3:0] wild, input logic allow_in);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      start             <= 1'b1;
      req_operation     <= op;
      req_address       <= (op == OP_CLEAR) ? $urandom : addr;
      req_range_end     <= (op == OP_ADD_RANGE) ? rend : $urandom;
      req_wildcard_mask <= (op == OP_ADD_RULE) ? wild : 4'($urandom);
      req_rule_allow    <= (op == OP_ADD_RULE) ? allow_in : 1'($urandom);
      if (op == OP_ADD_RULE || op == OP_ADD_RANGE)
         addr_pool = {addr_pool, addr};
      if (op == OP_ADD_RANGE)
         addr_pool = {addr_pool, rend};
      while (addr_pool.size() > 32)
         void'(addr_pool.pop_front());
      items_sent++;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue(OP_CHECK,     32'h0000_0000, '0, '0, 1'b0);
      issue(OP_CHECK,     32'hFFFF_FFFF, '0, '0, 1'b0);
      issue(OP_ADD_RULE,  32'h0A00_0000, '0, 4'b0111, 1'b0);
      issue(OP_CHECK,     32'h0A01_0203, '0, '0, 1'b0);
      issue(OP_CHECK,     32'h0B01_0203, '0, '0, 1'b0);
      issue(OP_ADD_RULE,  32'h0A01_0203, '0, 4'b0000, 1'b1);
      issue(OP_CHECK,     32'h0A01_0203, '0, '0, 1'b0);
      issue(OP_CHECK,     32'h0A01_0204, '0, '0, 1'b0);
      issue(OP_ADD_RULE,  32'h0000_0000, '0, 4'b1111, 1'b0);
      issue(OP_CHECK,     32'hC0A8_0001, '0, '0, 1'b0);
      issue(OP_ADD_RANGE, 32'h0000_0000, 32'h0000_0000, '0, 1'b0);
      issue(OP_ADD_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0);
      // reversed range stores but never matches
      issue(OP_ADD_RANGE, 32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b0);
      issue(OP_ADD_RANGE, 32'h0102_0304, 32'h0102_0310, '0, 1'b0);
      issue(OP_CHECK,     32'h0000_0000, '0, '0, 1'b0);
      issue(OP_CHECK,     32'hFFFF_FFFF, '0, '0, 1'b0);
      issue(OP_CHECK,     32'h8000_0000, '0, '0, 1'b0);
      issue(OP_CHECK,     32'h0102_0303, '0, '0, 1'b0);
      issue(OP_CHECK,     32'h0102_0310, '0, '0, 1'b0);
      issue(OP_CLEAR,     '0, '0, '0, 1'b0);
      issue(OP_CHECK,     32'h0A01_0203, '0, '0, 1'b0);
      issue(OP_ADD_RULE,  32'hFFFF_FFFF, '0, 4'b0000, 1'b1);
      issue(OP_CHECK,     32'hFFFF_FFFF, '0, '0, 1'b0);

      // Phases start from empty tables; crowded phases are longer and weighted more heavily toward adds.
      while (items_sent < ITEM_TARGET) begin
         crowded    = ($urandom_range(0, 5) == 0);
         phase_len  = crowded ? $urandom_range(140, 170) : $urandom_range(20, 60);
         add_weight = crowded ? 45 : 18;
         issue(OP_CLEAR, '0, '0, '0, 1'b0);
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            if (pick < add_weight) begin
               lo = $urandom_range(0, 1) ? pool_pick() : $urandom;
               issue(OP_ADD_RULE, lo, '0, 4'($urandom), 1'($urandom));
            end else if (pick < 2 * add_weight) begin
               kind = $urandom_range(0, 9);
               lo = (kind < 5) ? pool_pick() : $urandom;
               if (kind < 7) begin
                  span = {1'b0, lo} + 33'($urandom_range(0, 4096));
                  hi = span[32] ? 32'hFFFF_FFFF : span[31:0];
               end else if (kind == 7) begin
                  hi = lo;
               end else if (kind == 8) begin
                  hi = lo - 32'($urandom_range(1, 1000));
               end else begin
                  hi = $urandom;
               end
               issue(OP_ADD_RANGE, lo, hi, '0, 1'b0);
            end else if (pick < 99) begin
               kind = $urandom_range(0, 9);
               if (kind < 5) begin
                  lo = pool_pick();
                  for (int k = 0; k < 4; k++)
                     if ($urandom_range(0, 3) == 0)
                        lo[8*k +: 8] = 8'($urandom);
               end else if (kind < 7) begin
                  lo = pool_pick() + 32'($urandom_range(0, 2)) - 32'd1;
               end else if (kind == 7) begin
                  case ($urandom_range(0, 3))
                     0: lo = 32'h0000_0000;
                     1: lo = 32'hFFFF_FFFF;
                     2: lo = 32'h8000_0000;
                     default: lo = 32'h7FFF_FFFF;
                  endcase
               end else begin
                  lo = $urandom;
               end
               issue(OP_CHECK, lo, '0, '0, 1'b0);
            end else begin
               issue(OP_CLEAR, '0, '0, '0, 1'b0);
            end
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (answers_pending != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

/* ip_access_filter.f */
sv/ipaf_pkg.sv
sv/ip_access_filter.sv
tb/ipaf_checker.sv
tb/testbench.sv
